// ===== src/iif_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iif_pkg
// Shared constants and widths for the interpolated integral factor block.
// ----------------------------------------------------------------------------
package iif_pkg;

  // Table geometry and time line scaling
  localparam int TABLE_DEPTH = 10000;
  localparam int TIME_BITS   = 56;
  localparam int NUM_TABLES  = 5;

  // Fixed field widths
  localparam int OP_W     = 1;
  localparam int SEL_W    = 3;
  localparam int LIDX_W   = 14;
  localparam int VAL_W    = 48;
  localparam int TI_W     = 57;
  localparam int FACTOR_W = VAL_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Derived widths
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int DEPTH_W    = $clog2(TABLE_DEPTH + 1);
  localparam int HALF_DEPTH = (TABLE_DEPTH + 1) / 2;
  localparam int BANK_DEPTH = NUM_TABLES * HALF_DEPTH;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int PROD_W     = TI_W + DEPTH_W;
  localparam int WI_W       = PROD_W - TIME_BITS;
  localparam int IX_W       = (WI_W > IDX_W) ? WI_W : IDX_W;
  localparam int FRAC_W     = 32;
  localparam int HALF_MAG_W = VAL_W / 2;
  localparam int PLO_W      = HALF_MAG_W + FRAC_W;
  localparam int PHI_W      = (VAL_W - HALF_MAG_W) + FRAC_W;
  localparam int PINT_W     = VAL_W + WI_W;
  localparam int SUM_W      = VAL_W + FRAC_W + WI_W + 1;
  localparam int Q_W        = SUM_W - FRAC_W;
  localparam int M_W        = 51;
  localparam int V_W        = 52;
  localparam int D_W        = V_W + 1;

  // Product cap 2^50 and factor limit 2^48-1
  localparam logic [M_W-1:0]      PROD_CAP   = {1'b1, {(M_W-1){1'b0}}};
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = {1'b0, {VAL_W{1'b1}}};

endpackage

// ===== src/interpolated_integral_factor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolated_integral_factor
// Five loaded Q16.32 cumulative integral tables; a query interpolates the
// selected table at two time line points and returns their difference.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake        Fields
//  --------  ---------------  -----------------------------------------------
//  input     start & !busy    operation, table_sel, load_index, load_value,
//                             span_start, ti_end
//  result    done (1 cycle)   factor, order_error
//
//  One item is taken every cycle while busy is low. For a query, done rises once
//  the item has passed every pipeline stage; a load gives none and is written into
//  the table store in the cycle after acceptance, so a query right behind it sees
//  the new entry. The tables sit in two banks (even and odd entries), each with one
//  write and two read ports, so both neighbors of both points come out together.
//  busy is set by reset and cleared at the next clock edge without reset. The table
//  store has no reset.
//
module interpolated_integral_factor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [iif_pkg::OP_W-1:0]      operation,
  input  logic [iif_pkg::SEL_W-1:0]     table_sel,
  input  logic [iif_pkg::LIDX_W-1:0]    load_index,
  input  logic [iif_pkg::VAL_W-1:0]     load_value,
  input  logic [iif_pkg::TI_W-1:0]      span_start,
  input  logic [iif_pkg::TI_W-1:0]      ti_end,
  output logic                          done,
  output logic [iif_pkg::FACTOR_W-1:0]  factor,
  output logic                          order_error
);

  import iif_pkg::*;

  // Table banks: even and odd entries of every table
  logic [VAL_W-1:0] mem_even [BANK_DEPTH];
  logic [VAL_W-1:0] mem_odd  [BANK_DEPTH];

  // Stage 1: registered input item
  logic              s1_vld;
  logic [OP_W-1:0]   s1_op;
  logic [SEL_W-1:0]  s1_sel;
  logic [LIDX_W-1:0] s1_lidx;
  logic [VAL_W-1:0]  s1_lval;
  logic [TI_W-1:0]   s1_ti [2];

  // Stage 1 logic
  logic              s1_sel_ok;
  logic [BANK_AW-1:0] s1_tbase;
  logic              s1_we;
  logic [BANK_AW-1:0] s1_waddr;
  logic [PROD_W-1:0] s1_prod [2];

  // Stage 2: scaled time points
  logic               s2_vld;
  logic               s2_sel_ok;
  logic               s2_oerr;
  logic [BANK_AW-1:0] s2_tbase;
  logic [PROD_W-1:0]  s2_prod [2];

  // Stage 2 logic
  logic [IX_W-1:0]          s2_ipx   [2];
  logic [IDX_W-1:0]         s2_idx   [2];
  logic [WI_W-1:0]          s2_wint  [2];
  logic [TIME_BITS+31:0]    s2_fx    [2];
  logic [BANK_AW-1:0]       s2_half  [2];
  logic [BANK_AW-1:0]       s2_aeven [2];
  logic [BANK_AW-1:0]       s2_aodd  [2];

  // Stage 3: entries read
  logic              s3_vld;
  logic              s3_sel_ok;
  logic              s3_oerr;
  logic [FRAC_W-1:0] s3_frac  [2];
  logic [WI_W-1:0]   s3_wint  [2];
  logic              s3_idx0  [2];
  logic              s3_odd   [2];
  logic [VAL_W-1:0]  s3_reven [2];
  logic [VAL_W-1:0]  s3_rodd  [2];

  // Stage 3 logic
  logic [VAL_W-1:0]        s3_cur  [2];
  logic [VAL_W-1:0]        s3_prev [2];
  logic signed [VAL_W:0]   s3_d    [2];
  logic signed [VAL_W:0]   s3_absd [2];

  // Stage 4: magnitude, sign and base
  logic              s4_vld;
  logic              s4_sel_ok;
  logic              s4_oerr;
  logic [VAL_W-1:0]  s4_mag  [2];
  logic              s4_neg  [2];
  logic [VAL_W-1:0]  s4_base [2];
  logic [FRAC_W-1:0] s4_frac [2];
  logic [WI_W-1:0]   s4_wint [2];

  // Stage 5: partial products
  logic              s5_vld;
  logic              s5_sel_ok;
  logic              s5_oerr;
  logic [PLO_W-1:0]  s5_plo  [2];
  logic [PHI_W-1:0]  s5_phi  [2];
  logic [PINT_W-1:0] s5_pint [2];
  logic              s5_neg  [2];
  logic [VAL_W-1:0]  s5_base [2];

  // Stage 5 logic
  logic [SUM_W-1:0] s5_sum [2];
  logic [Q_W-1:0]   s5_q   [2];

  // Stage 6: capped products
  logic             s6_vld;
  logic             s6_sel_ok;
  logic             s6_oerr;
  logic [M_W-1:0]   s6_m    [2];
  logic             s6_neg  [2];
  logic [VAL_W-1:0] s6_base [2];

  // Stage 7: point values
  logic                  s7_vld;
  logic                  s7_sel_ok;
  logic                  s7_oerr;
  logic signed [V_W-1:0] s7_val [2];

  // Final difference
  logic signed [D_W-1:0] diff;
  logic signed [D_W-1:0] fmax;
  logic [FACTOR_W-1:0]   factor_next;

  // ---------------------------------------------------------------------------
  // Control: valid bits and busy
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b1;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy   <= 1'b0;
      s1_vld <= start && !busy;
      s2_vld <= s1_vld && (s1_op == OP_QUERY);
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
      done   <= s7_vld;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s1_op    <= operation;
    s1_sel   <= table_sel;
    s1_lidx  <= load_index;
    s1_lval  <= load_value;
    s1_ti[0] <= span_start;
    s1_ti[1] <= ti_end;
  end

  // Table base, load write and time scaling
  always_comb begin
    s1_sel_ok = (32'(s1_sel) < 32'(NUM_TABLES));
    s1_tbase  = s1_sel_ok ? BANK_AW'(s1_sel) * BANK_AW'(HALF_DEPTH) : '0;
    s1_we     = s1_vld && (s1_op == OP_LOAD) && s1_sel_ok &&
                (32'(s1_lidx) < 32'(TABLE_DEPTH));
    s1_waddr  = s1_tbase + BANK_AW'(s1_lidx[LIDX_W-1:1]);
    for (int p = 0; p < 2; p++) begin
      s1_prod[p] = PROD_W'(s1_ti[p]) * PROD_W'(TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    s2_sel_ok <= s1_sel_ok;
    s2_oerr   <= (s1_ti[1] < s1_ti[0]);
    s2_tbase  <= s1_tbase;
    s2_prod   <= s1_prod;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: integer part, fraction, clamped index, bank addresses
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      s2_ipx[p]  = IX_W'(s2_prod[p][PROD_W-1:TIME_BITS]);
      s2_idx[p]  = (s2_ipx[p] >= IX_W'(TABLE_DEPTH - 1)) ?
                   IDX_W'(TABLE_DEPTH - 1) : IDX_W'(s2_ipx[p]);
      s2_wint[p] = WI_W'(s2_ipx[p] - IX_W'(s2_idx[p]));
      s2_fx[p]   = {s2_prod[p][TIME_BITS-1:0], 32'b0};
      s2_half[p] = s2_tbase + BANK_AW'(s2_idx[p][IDX_W-1:1]);
      s2_aeven[p] = s2_half[p];
      // odd bank holds entry idx when odd, entry idx-1 when even (entry 1 for idx 0)
      if (s2_idx[p][0]) begin
        s2_aodd[p] = s2_half[p];
      end else if (s2_idx[p] == '0) begin
        s2_aodd[p] = s2_tbase;
      end else begin
        s2_aodd[p] = s2_half[p] - BANK_AW'(1);
      end
    end
  end

  // Table banks: load write and query reads
  always_ff @(posedge clk) begin
    if (s1_we && !s1_lidx[0]) begin
      mem_even[s1_waddr] <= s1_lval;
    end
    if (s1_we && s1_lidx[0]) begin
      mem_odd[s1_waddr] <= s1_lval;
    end
    for (int p = 0; p < 2; p++) begin
      s3_reven[p] <= mem_even[s2_aeven[p]];
      s3_rodd[p]  <= mem_odd[s2_aodd[p]];
    end
  end

  always_ff @(posedge clk) begin
    s3_sel_ok <= s2_sel_ok;
    s3_oerr   <= s2_oerr;
    for (int p = 0; p < 2; p++) begin
      s3_frac[p] <= s2_fx[p][TIME_BITS+31:TIME_BITS];
      s3_wint[p] <= s2_wint[p];
      s3_idx0[p] <= (s2_idx[p] == '0);
      s3_odd[p]  <= s2_idx[p][0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: neighbor difference, magnitude and sign
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      s3_cur[p]  = s3_odd[p] ? s3_rodd[p] : s3_reven[p];
      s3_prev[p] = s3_odd[p] ? s3_reven[p] : s3_rodd[p];
      s3_d[p]    = $signed({1'b0, s3_cur[p]}) - $signed({1'b0, s3_prev[p]});
      s3_absd[p] = s3_d[p][VAL_W] ? -s3_d[p] : s3_d[p];
    end
  end

  always_ff @(posedge clk) begin
    s4_sel_ok <= s3_sel_ok;
    s4_oerr   <= s3_oerr;
    for (int p = 0; p < 2; p++) begin
      s4_frac[p] <= s3_frac[p];
      s4_wint[p] <= s3_wint[p];
      // first segment scales entry 0 from the origin
      if (s3_idx0[p]) begin
        s4_mag[p]  <= s3_reven[p];
        s4_neg[p]  <= 1'b0;
        s4_base[p] <= '0;
      end else begin
        s4_mag[p]  <= s3_absd[p][VAL_W-1:0];
        s4_neg[p]  <= s3_d[p][VAL_W];
        s4_base[p] <= s3_prev[p];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products of magnitude and weight
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s5_sel_ok <= s4_sel_ok;
    s5_oerr   <= s4_oerr;
    for (int p = 0; p < 2; p++) begin
      s5_plo[p]  <= PLO_W'(s4_mag[p][HALF_MAG_W-1:0]) * PLO_W'(s4_frac[p]);
      s5_phi[p]  <= PHI_W'(s4_mag[p][VAL_W-1:HALF_MAG_W]) * PHI_W'(s4_frac[p]);
      s5_pint[p] <= PINT_W'(s4_mag[p]) * PINT_W'(s4_wint[p]);
      s5_neg[p]  <= s4_neg[p];
      s5_base[p] <= s4_base[p];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum partials, drop fraction, cap at 2^50
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      s5_sum[p] = SUM_W'(s5_plo[p]) + (SUM_W'(s5_phi[p]) << HALF_MAG_W) +
                  (SUM_W'(s5_pint[p]) << FRAC_W);
      s5_q[p]   = s5_sum[p][SUM_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    s6_sel_ok <= s5_sel_ok;
    s6_oerr   <= s5_oerr;
    for (int p = 0; p < 2; p++) begin
      s6_m[p]    <= (s5_q[p] > Q_W'(PROD_CAP)) ? PROD_CAP : s5_q[p][M_W-1:0];
      s6_neg[p]  <= s5_neg[p];
      s6_base[p] <= s5_base[p];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: point value = base +/- product
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s7_sel_ok <= s6_sel_ok;
    s7_oerr   <= s6_oerr;
    for (int p = 0; p < 2; p++) begin
      if (s6_neg[p]) begin
        s7_val[p] <= $signed(V_W'(s6_base[p])) - $signed(V_W'(s6_m[p]));
      end else begin
        s7_val[p] <= $signed(V_W'(s6_base[p])) + $signed(V_W'(s6_m[p]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: end minus start, saturated; zero for an unknown table
  // ---------------------------------------------------------------------------
  always_comb begin
    fmax = $signed(D_W'(FACTOR_MAX));
    diff = D_W'(s7_val[1]) - D_W'(s7_val[0]);
    if (!s7_sel_ok) begin
      factor_next = '0;
    end else if (diff > fmax) begin
      factor_next = FACTOR_MAX;
    end else if (diff < -fmax) begin
      factor_next = FACTOR_W'(-fmax);
    end else begin
      factor_next = diff[FACTOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    factor      <= factor_next;
    order_error <= s7_oerr;
  end

endmodule
